### sv/arc_angle_normalizer_macros.svh
// ---------------------------------------------------------------------------
// Arc angle normaliser assertion macros
// Shared property wrappers for the checker of the arc angle normaliser.
// ---------------------------------------------------------------------------
`ifndef ARC_ANGLE_NORMALIZER_MACROS_SVH
`define ARC_ANGLE_NORMALIZER_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define ARCN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked property that also holds while reset is asserted.
`define ARCN_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### sv/arcn_pkg.sv
// ---------------------------------------------------------------------------
// Arc angle normaliser package
// Types, constants and the arctangent table shared by the normaliser.
// ---------------------------------------------------------------------------
`default_nettype none

package arcn_pkg;

    // How the back end produces the corrected angles of a request.
    typedef enum logic [1:0] {
        MODE_PASS   = 2'd0,
        MODE_ZERO   = 2'd1,
        MODE_CORDIC = 2'd2
    } arcn_mode_t;

    // Register addresses (index in the register list).
    localparam int unsigned REG_CORRECT = 0;

    // Rotation datapath: unit vector 2^26, gain keeps it below 2^27.
    localparam int unsigned RW = 28;
    // Residual angle accumulator of the rotation CORDIC.
    localparam int unsigned ZW = 34;
    localparam logic signed [RW-1:0] UNIT_VEC = RW'(64'd67108864);

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] THREE_QUART  = 32'hC000_0000;
    localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;

    // atan(2^-i) in units of 2^32 per turn.
    function automatic logic [31:0] atan_tab(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/arcn_front.sv
// ---------------------------------------------------------------------------
// Arc angle normaliser front end
// Accepts requests, wraps both angles into one turn and classifies them.
// ---------------------------------------------------------------------------
`default_nettype none

module arcn_front import arcn_pkg::*; #(
    parameter int unsigned ANGLE_FRAC_BITS = 16,
    parameter int unsigned DIM_BITS        = 20,
    localparam int unsigned FW = 2 * ANGLE_FRAC_BITS + 2 * DIM_BITS + 3
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                correct,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [31:0]         in_start,
    input  wire logic [31:0]         in_stop,
    input  wire logic [DIM_BITS-1:0] in_width,
    input  wire logic [DIM_BITS-1:0] in_height,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output logic [FW-1:0]            push_data
);

    logic              vld_reg;
    logic [FW-1:0]     item_reg;
    logic [ANGLE_FRAC_BITS-1:0] st_w, sp_w;
    arcn_mode_t        mode;

    assign st_w = in_start[ANGLE_FRAC_BITS-1:0];
    assign sp_w = in_stop[ANGLE_FRAC_BITS-1:0];

    always_comb begin
        priority if (!correct) begin
            mode = MODE_PASS;
        end else if (in_width == '0 && in_height == '0) begin
            mode = MODE_ZERO;
        end else if (in_width == in_height) begin
            mode = MODE_PASS;
        end else begin
            mode = MODE_CORDIC;
        end
    end

    assign in_ready   = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_data  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            vld_reg <= 1'b1;
        end else if (push_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= {mode, (st_w == sp_w), in_height, in_width, sp_w, st_w};
        end
    end

endmodule

`default_nettype wire

### sv/arcn_fifo.sv
// ---------------------------------------------------------------------------
// Arc angle normaliser request queue
// Short queue between the front end and the CORDIC back end.
// ---------------------------------------------------------------------------
`default_nettype none

module arcn_fifo import arcn_pkg::*; #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] buf_reg [0:DEPTH-1];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = count_reg != (AW+1)'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = buf_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            buf_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### sv/arcn_back.sv
// ---------------------------------------------------------------------------
// Arc angle normaliser back end
// Pipelined rotation and vectoring CORDIC for both angles, then ordering.
// ---------------------------------------------------------------------------
`default_nettype none

module arcn_back import arcn_pkg::*; #(
    parameter int unsigned ANGLE_FRAC_BITS = 16,
    parameter int unsigned DIM_BITS        = 20,
    parameter int unsigned CORDIC_STAGES   = 16,
    localparam int unsigned FW = 2 * ANGLE_FRAC_BITS + 2 * DIM_BITS + 3
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [FW-1:0]              in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [ANGLE_FRAC_BITS-1:0]      out_start,
    output logic [ANGLE_FRAC_BITS:0]        out_stop,
    output logic                            out_same
);

    localparam int unsigned AF  = ANGLE_FRAC_BITS;
    localparam int unsigned N   = CORDIC_STAGES;
    localparam int unsigned PW  = RW + DIM_BITS + 1;
    localparam int unsigned VW  = DIM_BITS + 31;
    localparam int unsigned LAT = 2 * N + 4;

    logic en;

    // Sideband travelling alongside the datapath.
    logic                vld_reg   [0:LAT-1];
    logic [AF-1:0]       sst_reg   [0:LAT-2];
    logic [AF-1:0]       ssp_reg   [0:LAT-2];
    logic [DIM_BITS-1:0] sw_reg    [0:LAT-2];
    logic [DIM_BITS-1:0] sh_reg    [0:LAT-2];
    logic                ssame_reg [0:LAT-2];
    arcn_mode_t          smode_reg [0:LAT-2];

    // Rotation CORDIC, one lane per angle.
    logic signed [RW-1:0] rx_reg [0:N][0:1];
    logic signed [RW-1:0] ry_reg [0:N][0:1];
    logic signed [ZW-1:0] rz_reg [0:N][0:1];
    logic [1:0]           rq_reg [0:N][0:1];
    logic                 r0_reg [0:N][0:1];

    // Scaled vector.
    logic signed [PW-1:0] mx_reg [0:1];
    logic signed [PW-1:0] my_reg [0:1];

    // Vectoring CORDIC.
    logic signed [VW-1:0] vx_reg [0:N][0:1];
    logic signed [VW-1:0] vy_reg [0:N][0:1];
    logic [31:0]          vz_reg [0:N][0:1];
    logic                 vf_reg [0:N][0:1];

    logic [AF-1:0] ost_reg;
    logic [AF:0]   osp_reg;
    logic          osame_reg;

    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];
    assign out_start = ost_reg;
    assign out_stop  = osp_reg;
    assign out_same  = osame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sst_reg[0]   <= in_data[AF-1:0];
            ssp_reg[0]   <= in_data[2*AF-1:AF];
            sw_reg[0]    <= in_data[2*AF+DIM_BITS-1:2*AF];
            sh_reg[0]    <= in_data[2*AF+2*DIM_BITS-1:2*AF+DIM_BITS];
            ssame_reg[0] <= in_data[2*AF+2*DIM_BITS];
            smode_reg[0] <= arcn_mode_t'(in_data[FW-1:FW-2]);
            for (int k = 1; k < LAT - 1; k++) begin
                sst_reg[k]   <= sst_reg[k-1];
                ssp_reg[k]   <= ssp_reg[k-1];
                sw_reg[k]    <= sw_reg[k-1];
                sh_reg[k]    <= sh_reg[k-1];
                ssame_reg[k] <= ssame_reg[k-1];
                smode_reg[k] <= smode_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [AF-1:0]  ang;
        logic [31:0]    a32, aq, ru;
        logic signed [RW-1:0] xs, ys, cv, sv;
        logic signed [PW-1:0] px, py;
        logic signed [DIM_BITS:0] hs, ws;
        logic signed [VW-1:0] ex, ey;

        // Quadrant split leaves a residual within an eighth of a turn.
        assign ang = (l == 0) ? in_data[AF-1:0] : in_data[2*AF-1:AF];
        assign a32 = {ang, {(32-AF){1'b0}}};
        assign aq  = a32 + EIGHTH_TURN;
        assign ru  = a32 - {aq[31:30], 30'd0};

        always_ff @(posedge aclk) begin
            if (en) begin
                rx_reg[0][l] <= UNIT_VEC;
                ry_reg[0][l] <= '0;
                rz_reg[0][l] <= {{(ZW-32){ru[31]}}, ru};
                rq_reg[0][l] <= aq[31:30];
                r0_reg[0][l] <= ru == '0;
            end
        end

        for (genvar j = 0; j < N; j++) begin : g_rot
            logic signed [ZW-1:0] at;
            assign at = $signed({{(ZW-32){1'b0}}, atan_tab(5'(j))});
            always_ff @(posedge aclk) begin
                if (en) begin
                    rq_reg[j+1][l] <= rq_reg[j][l];
                    r0_reg[j+1][l] <= r0_reg[j][l];
                    if (!rz_reg[j][l][ZW-1]) begin
                        rx_reg[j+1][l] <= rx_reg[j][l] - (ry_reg[j][l] >>> j);
                        ry_reg[j+1][l] <= ry_reg[j][l] + (rx_reg[j][l] >>> j);
                        rz_reg[j+1][l] <= rz_reg[j][l] - at;
                    end else begin
                        rx_reg[j+1][l] <= rx_reg[j][l] + (ry_reg[j][l] >>> j);
                        ry_reg[j+1][l] <= ry_reg[j][l] - (rx_reg[j][l] >>> j);
                        rz_reg[j+1][l] <= rz_reg[j][l] + at;
                    end
                end
            end
        end

        // A zero residual takes the exact unit vector.
        assign xs = r0_reg[N][l] ? UNIT_VEC : rx_reg[N][l];
        assign ys = r0_reg[N][l] ? '0 : ry_reg[N][l];

        always_comb begin
            unique case (rq_reg[N][l])
                2'd0: begin cv = xs;  sv = ys;  end
                2'd1: begin cv = -ys; sv = xs;  end
                2'd2: begin cv = -xs; sv = -ys; end
                default: begin cv = ys; sv = -xs; end
            endcase
        end

        assign hs = $signed({1'b0, sh_reg[N]});
        assign ws = $signed({1'b0, sw_reg[N]});
        assign px = cv * hs;
        assign py = sv * ws;

        always_ff @(posedge aclk) begin
            if (en) begin
                mx_reg[l] <= px;
                my_reg[l] <= py;
            end
        end

        assign ex = {{(VW-PW){mx_reg[l][PW-1]}}, mx_reg[l]};
        assign ey = {{(VW-PW){my_reg[l][PW-1]}}, my_reg[l]};

        // Axis vectors are exact; negative x is turned by half a turn.
        always_ff @(posedge aclk) begin
            if (en) begin
                vx_reg[0][l] <= ex;
                vy_reg[0][l] <= ey;
                vz_reg[0][l] <= '0;
                vf_reg[0][l] <= 1'b0;
                priority if (ey == '0) begin
                    vf_reg[0][l] <= 1'b1;
                    vz_reg[0][l] <= ex[VW-1] ? HALF_TURN : '0;
                end else if (ex == '0) begin
                    vf_reg[0][l] <= 1'b1;
                    vz_reg[0][l] <= ey[VW-1] ? THREE_QUART : QUARTER_TURN;
                end else if (ex[VW-1]) begin
                    vx_reg[0][l] <= -ex;
                    vy_reg[0][l] <= -ey;
                    vz_reg[0][l] <= HALF_TURN;
                end
            end
        end

        for (genvar j = 0; j < N; j++) begin : g_vec
            logic [31:0] at;
            assign at = atan_tab(5'(j));
            always_ff @(posedge aclk) begin
                if (en) begin
                    vf_reg[j+1][l] <= vf_reg[j][l];
                    if (vf_reg[j][l]) begin
                        vx_reg[j+1][l] <= vx_reg[j][l];
                        vy_reg[j+1][l] <= vy_reg[j][l];
                        vz_reg[j+1][l] <= vz_reg[j][l];
                    end else if (!vy_reg[j][l][VW-1] && vy_reg[j][l] != '0) begin
                        vx_reg[j+1][l] <= vx_reg[j][l] + (vy_reg[j][l] >>> j);
                        vy_reg[j+1][l] <= vy_reg[j][l] - (vx_reg[j][l] >>> j);
                        vz_reg[j+1][l] <= vz_reg[j][l] + at;
                    end else begin
                        vx_reg[j+1][l] <= vx_reg[j][l] - (vy_reg[j][l] >>> j);
                        vy_reg[j+1][l] <= vy_reg[j][l] + (vx_reg[j][l] >>> j);
                        vz_reg[j+1][l] <= vz_reg[j][l] - at;
                    end
                end
            end
        end
    end

    // Round to the output resolution, half up, wrapping at a full turn.
    logic [31:0]   zs0, zs1;
    logic [AF-1:0] st_f, sp_f;

    assign zs0 = vz_reg[N][0] + (32'd1 << (31 - AF));
    assign zs1 = vz_reg[N][1] + (32'd1 << (31 - AF));

    always_comb begin
        unique case (smode_reg[LAT-2])
            MODE_ZERO: begin
                st_f = '0;
                sp_f = '0;
            end
            MODE_CORDIC: begin
                st_f = zs0[31:32-AF];
                sp_f = zs1[31:32-AF];
            end
            default: begin
                st_f = sst_reg[LAT-2];
                sp_f = ssp_reg[LAT-2];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ost_reg   <= st_f;
            osp_reg   <= (st_f > sp_f) ? {1'b1, sp_f} : {1'b0, sp_f};
            osame_reg <= ssame_reg[LAT-2];
        end
    end

endmodule

`default_nettype wire

### sv/arc_angle_normalizer.sv
// ---------------------------------------------------------------------------
// Arc angle normaliser
// Puts the start and stop angles of an elliptic arc into canonical form.
// ---------------------------------------------------------------------------
// Angles are binary angle units with ANGLE_FRAC_BITS fraction bits per turn.
// Each request carries a start and stop angle and the ellipse width and
// height; both angles are wrapped into one turn and same_point reports
// whether the wrapped values match. With correction enabled (register 0,
// reset value 1) each angle is replaced by atan2(width*sin, height*cos),
// computed by a rotation CORDIC, two multipliers and a vectoring CORDIC, all
// fully pipelined. Finally stop gains one turn if it lies below start. The
// block takes one request per clock cycle while the output is not stalled;
// each result passes the front register, the queue, the quadrant split
// register, the rotation CORDIC, the multiply register, the pre-rotation
// register, the vectoring CORDIC and the rounding register. A four-entry
// queue separates the front end from the pipeline so that input acceptance
// continues while a result waits on the output.
// ---------------------------------------------------------------------------
`default_nettype none

module arc_angle_normalizer import arcn_pkg::*; #(
    parameter int unsigned ANGLE_FRAC_BITS = 16,
    parameter int unsigned DIM_BITS        = 20,
    parameter int unsigned CORDIC_STAGES   = 16,
    localparam int unsigned S_W = ((64 + 2 * DIM_BITS + 7) / 8) * 8,
    localparam int unsigned M_W = ((2 * ANGLE_FRAC_BITS + 2 + 7) / 8) * 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // Configuration port.
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Input requests.
    input  wire logic           s_tvalid,
    output logic                s_tready,
    // start_angle, stop_angle, ellipse_width, ellipse_height, padding bits if any
    input  wire logic [S_W-1:0] s_tdata,
    // Results.
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // start_out, stop_out, same_point, zero padding
    output logic [M_W-1:0]      m_tdata
);

    localparam int unsigned AF = ANGLE_FRAC_BITS;
    localparam int unsigned FW = 2 * AF + 2 * DIM_BITS + 3;

    logic           correct_reg;
    logic           push_valid, push_ready, pop_valid, pop_ready;
    logic [FW-1:0]  push_data, pop_data;
    logic [AF-1:0]  start_out;
    logic [AF:0]    stop_out;
    logic           same_point;

    // The single register holds the correction enable; pready is constant.
    assign pready = 1'b1;
    assign prdata = (paddr == 3'(REG_CORRECT * 4)) ? {31'd0, correct_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            correct_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr == 3'(REG_CORRECT * 4)) begin
            correct_reg <= pwdata[0];
        end
    end

    // Front end: wraps both angles and decides which path the request takes.
    arcn_front #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .DIM_BITS       (DIM_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .correct   (correct_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_start  (s_tdata[31:0]),
        .in_stop   (s_tdata[63:32]),
        .in_width  (s_tdata[64+DIM_BITS-1:64]),
        .in_height (s_tdata[64+2*DIM_BITS-1:64+DIM_BITS]),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data)
    );

    arcn_fifo #(
        .WIDTH(FW)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_data (push_data),
        .rd_valid(pop_valid),
        .rd_ready(pop_ready),
        .rd_data (pop_data)
    );

    // Back end: the whole pipeline advances together whenever the output
    // register is free or being emptied.
    arcn_back #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .DIM_BITS       (DIM_BITS),
        .CORDIC_STAGES  (CORDIC_STAGES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pop_valid),
        .in_ready (pop_ready),
        .in_data  (pop_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_start(start_out),
        .out_stop (stop_out),
        .out_same (same_point)
    );

    assign m_tdata = M_W'({same_point, stop_out, start_out});

endmodule

`default_nettype wire

### sv/arcn_checker.sv
// ---------------------------------------------------------------------------
// Arc angle normaliser checker
// Port-level properties of the normaliser, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "arc_angle_normalizer_macros.svh"

module arcn_checker #(
    parameter int unsigned ANGLE_FRAC_BITS = 16,
    parameter int unsigned M_W             = 40
) (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           m_tvalid,
    input wire logic           m_tready,
    input wire logic [M_W-1:0] m_tdata
);

    localparam int unsigned AF = ANGLE_FRAC_BITS;

    logic [AF:0] start_x, stop_x, turn_x;
    logic        same_x;

    assign start_x = {1'b0, m_tdata[AF-1:0]};
    assign stop_x  = m_tdata[2*AF:AF];
    assign same_x  = m_tdata[2*AF+1];
    assign turn_x  = {1'b1, {AF{1'b0}}};

    `ARCN_ASSERT_RST(a_idle_after_reset, !aresetn |=> !m_tvalid, "result valid after reset")
    `ARCN_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `ARCN_ASSERT(a_stop_order, m_tvalid |-> stop_x >= start_x && stop_x - start_x < turn_x, "stop not within one turn above start")
    `ARCN_ASSERT(a_same_equal, m_tvalid && same_x |-> stop_x == start_x, "same point with differing angles")

endmodule

bind arc_angle_normalizer arcn_checker #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .M_W            (M_W)
) u_arcn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire

### bench/tb_arc_angle_normalizer.sv
// ---------------------------------------------------------------------------
// Arc angle normaliser testbench
// Drives start/stop angles and ellipse sizes through the stream port and
// checks every result against a typed value or a bit-accurate CORDIC predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_arc_angle_normalizer;
    import arcn_pkg::*;

    localparam int unsigned S_W       = 104;
    localparam int unsigned M_W       = 40;
    localparam int unsigned STAGES    = 16;
    localparam int unsigned N_RANDOM  = 1800;
    localparam int unsigned LATENCY   = 2 * STAGES + 5;
    localparam int unsigned CYCLE_CAP = 400000;

    // One result of the block: the two normalised angles and the match flag.
    typedef struct packed {
        logic [15:0] start_o;
        logic [16:0] stop_o;
        logic        same;
    } arc_res_t;

    // A row of the directed table; the result is typed in only where it is
    // obvious, otherwise the predictor supplies it.
    typedef struct {
        logic [31:0] start_a;
        logic [31:0] stop_a;
        logic [19:0] wid;
        logic [19:0] hgt;
        bit          typed;
        arc_res_t    res;
    } arc_row_t;

    // atan(2^-i) in units of 2^32 per turn.
    localparam logic [31:0] ARCTAN [0:15] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // start_angle, stop_angle, ellipse_width, ellipse_height
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // start_out, stop_out, same_point, zero padding
    logic [M_W-1:0] m_tdata;

    // Predictor copy of the correction register and the pending results.
    bit       scaling_on = 1'b1;
    arc_res_t pending_arcs[$];
    int       errors = 0;
    int       arcs_seen = 0;
    int       cycles = 0;
    bit       sender_quiet = 1'b0;

    arc_angle_normalizer u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The run is cut short if it ever exceeds a generous cycle budget.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Rotation CORDIC: cosine and sine of a 32-bit turn fraction, with a
    // quadrant split so the residual stays within an eighth of a turn.
    function automatic void rotate_unit(input logic [31:0] ang,
                                        output longint cs, output longint sn);
        logic [31:0] sum;
        logic [1:0]  quad;
        logic [31:0] resid;
        longint      x, y, z, nx;
        sum   = ang + 32'h2000_0000;
        quad  = sum[31:30];
        resid = ang - {quad, 30'b0};
        z = longint'(signed'(resid));
        x = longint'(1) << 26;
        y = 0;
        // A zero residual is taken as the exact unit vector.
        if (z != 0) begin
            for (int i = 0; i < STAGES; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(ARCTAN[i]);
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(ARCTAN[i]);
                end
                x = nx;
            end
        end
        case (quad)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    // Vectoring CORDIC: the angle of (x, y) as a 32-bit turn fraction.
    function automatic logic [31:0] vector_angle(input longint xi, input longint yi);
        longint      x, y, nx;
        logic [31:0] z;
        x = xi;
        y = yi;
        z = '0;
        // Vectors on an axis give exact results without iterating.
        if (y == 0) return (x < 0) ? HALF_TURN : 32'h0;
        if (x == 0) return (y > 0) ? QUARTER_TURN : THREE_QUART;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ARCTAN[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ARCTAN[i];
            end
            x = nx;
        end
        return z;
    endfunction

    // Aspect correction of one wrapped angle.
    function automatic logic [15:0] stretch_angle(input logic [15:0] ang,
                                                  input logic [19:0] wid,
                                                  input logic [19:0] hgt);
        longint      cs, sn;
        logic [31:0] raw;
        logic [32:0] rounded;
        if (wid == 0 && hgt == 0) return 16'h0;
        if (wid == hgt) return ang;
        rotate_unit({ang, 16'h0}, cs, sn);
        raw = vector_angle(cs * longint'(hgt), sn * longint'(wid));
        rounded = {1'b0, raw} + 33'h8000;
        return rounded[31:16];
    endfunction

    function automatic arc_res_t normalise_arc(input logic [31:0] start_a,
                                               input logic [31:0] stop_a,
                                               input logic [19:0] wid,
                                               input logic [19:0] hgt,
                                               input bit scale);
        arc_res_t r;
        logic [15:0] st, sp;
        st = start_a[15:0];
        sp = stop_a[15:0];
        r.same = (st == sp);
        if (scale) begin
            st = stretch_angle(st, wid, hgt);
            sp = stretch_angle(sp, wid, hgt);
        end
        r.start_o = st;
        r.stop_o  = (st > sp) ? {1'b0, sp} + 17'h1_0000 : {1'b0, sp};
        return r;
    endfunction

    task automatic write_correction(input bit val);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = 3'(4 * REG_CORRECT); pwdata = 32'(val);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        scaling_on = val;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Offers one request, queues its expected result when accepted, and returns
    // at the falling edge after acceptance with tvalid still high.
    task automatic send_arc(input logic [31:0] start_a, input logic [31:0] stop_a,
                            input logic [19:0] wid, input logic [19:0] hgt,
                            input bit typed, input arc_res_t res, input int gap);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {hgt, wid, stop_a, start_a};
        do @(posedge aclk); while (!s_tready);
        if (typed)
            pending_arcs.push_back(res);
        else
            pending_arcs.push_back(normalise_arc(start_a, stop_a, wid, hgt, scaling_on));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_arcs.size() != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    // Receiver: random back-pressure with one long hold-off early on, and
    // a quiet stretch where it always accepts.
    initial begin : result_sink
        int       hold;
        arc_res_t got, want;
        forever begin
            if (arcs_seen == 300) hold = 250;
            else if (arcs_seen > 1000 && arcs_seen < 1200) hold = 0;
            else hold = $urandom_range(0, 3);
            if (hold > 0) begin
                m_tready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            // The result fields sit in tdata from the lowest bit up.
            got.start_o = m_tdata[15:0];
            got.stop_o  = m_tdata[32:16];
            got.same    = m_tdata[33];
            arcs_seen++;
            if (pending_arcs.size() == 0) begin
                $display("%0t: unexpected result start=%h stop=%h same=%b", $time,
                         got.start_o, got.stop_o, got.same);
                errors++;
            end else begin
                want = pending_arcs.pop_front();
                if (got.start_o !== want.start_o) begin
                    $display("%0t: start_out expected %h actual %h", $time,
                             want.start_o, got.start_o);
                    errors++;
                end
                if (got.stop_o !== want.stop_o) begin
                    $display("%0t: stop_out expected %h actual %h", $time,
                             want.stop_o, got.stop_o);
                    errors++;
                end
                if (got.same !== want.same) begin
                    $display("%0t: same_point expected %b actual %b", $time,
                             want.same, got.same);
                    errors++;
                end
            end
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        arc_row_t    rows[$];
        arc_res_t    none;
        logic [31:0] a, b;
        logic [19:0] w, h;
        int          gap;
        int          kind;
        none = '0;
        // Extremes of the angle range, degenerate and square ellipses,
        // axis points and the same-point flag. Typed rows are only those
        // where correction leaves the wrapped angle or forces zero.
        rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 20'd16, 20'd16, 1,
                         '{16'h0000, 17'h0FFFF, 1'b0}});
        rows.push_back('{32'h0000_0000, 32'h0000_0000, 20'd0, 20'd0, 1,
                         '{16'h0000, 17'h00000, 1'b1}});
        rows.push_back('{32'h1234_4000, 32'h0000_4000, 20'd0, 20'd0, 1,
                         '{16'h0000, 17'h00000, 1'b1}});
        rows.push_back('{32'h0000_C000, 32'h0000_4000, 20'hFFFFF, 20'hFFFFF, 1,
                         '{16'hC000, 17'h14000, 1'b0}});
        rows.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 20'd5, 20'd5, 1,
                         '{16'hFFFF, 17'h10001, 1'b0}});
        rows.push_back('{32'h0000_0000, 32'h0000_4000, 20'hFFFFF, 20'd1, 0, none});
        rows.push_back('{32'h0000_8000, 32'h0000_C000, 20'd1, 20'hFFFFF, 0, none});
        rows.push_back('{32'h0000_2000, 32'h0000_6000, 20'd32, 20'd16, 0, none});
        rows.push_back('{32'hFFFF_E000, 32'h0000_A000, 20'd16, 20'd48, 0, none});
        rows.push_back('{32'h0000_1000, 32'h0000_1000, 20'hFFFFF, 20'd0, 0, none});
        rows.push_back('{32'h0000_3000, 32'h0000_9000, 20'd0, 20'hFFFFF, 0, none});
        rows.push_back('{32'h7FFF_0001, 32'h8000_FFFF, 20'd7, 20'd3, 0, none});
        rows.push_back('{32'h0000_FFFF, 32'h0000_0000, 20'd100, 20'd200, 0, none});

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i])
            send_arc(rows[i].start_a, rows[i].stop_a, rows[i].wid, rows[i].hgt,
                     rows[i].typed, rows[i].res, $urandom_range(0, 3));
        drain_results();

        // Random part, with the correction register toggled between phases.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 450 == 0) begin
                drain_results();
                write_correction((n / 450) % 2 == 0 ? 1'b0 : 1'b1);
            end
            // Once the sender waits for the pipeline to empty completely.
            if (n == 900) drain_results();
            a = $urandom();
            b = ($urandom_range(0, 7) == 0) ? {16'($urandom_range(0, 65535)), a[15:0]}
                                            : $urandom();
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin w = '0; h = '0; end
                1: begin w = 20'($urandom()); h = w; end
                2: begin w = '0; h = 20'($urandom()); end
                3: begin w = 20'($urandom()); h = '0; end
                4, 5: begin
                    w = 20'($urandom_range(1, 4096));
                    h = 20'($urandom_range(1, 4096));
                end
                default: begin w = 20'($urandom()); h = 20'($urandom()); end
            endcase
            gap = (n > 600 && n < 800) ? 0 : $urandom_range(0, 3);
            send_arc(a, b, w, h, 0, none, gap);
        end
        drain_results();

        if (errors == 0 && pending_arcs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/arcn_pkg.sv
sv/arcn_front.sv
sv/arcn_fifo.sv
sv/arcn_back.sv
sv/arc_angle_normalizer.sv
sv/arcn_checker.sv
bench/tb_arc_angle_normalizer.sv
